FILE: hw/rtl/mbrb_pkg.sv
// shared types, codes and defaults of the multichannel byte ring buffer
package mbrb_pkg;

    localparam int CHANNELS_DEFAULT = 8;
    localparam int RX_DEPTH_DEFAULT = 256;
    localparam int TX_DEPTH_DEFAULT = 256;

    localparam int CHAN_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic DIR_RX = 1'b0;
    localparam logic DIR_TX = 1'b1;

    typedef enum logic [1:0] {
        MODE_PUT    = 2'd0,
        MODE_GET    = 2'd1,
        MODE_REWIND = 2'd2,
        MODE_STATUS = 2'd3
    } mode_t;

    // decoded operation handed from front end to back end
    typedef enum logic [2:0] {
        OP_PUT,
        OP_GET,
        OP_REWIND,
        OP_STATUS,
        OP_REFUSE,
        OP_BAD_CHAN
    } op_t;

    typedef struct packed {
        mode_t               mode;
        logic [CHAN_W-1:0]   channel;
        logic                direction;
        logic [BYTE_W-1:0]   data_in;
        logic [BYTE_W-1:0]   rewind_count;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_out;
        logic                ok;
        logic [COUNT_W-1:0]  used_count;
        logic [COUNT_W-1:0]  free_count;
    } rsp_t;

    typedef struct packed {
        op_t                 op;
        logic [CHAN_W-1:0]   channel;
        logic                direction;
        logic [BYTE_W-1:0]   data_in;
        logic [BYTE_W-1:0]   rewind_count;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  used_count;
        logic [COUNT_W-1:0]  free_count;
    } ring_stat_t;

endpackage

FILE: hw/rtl/mbrb_req_if.sv
// request channel interface
interface mbrb_req_if;
    logic          valid;
    logic          ready;
    mbrb_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/mbrb_rsp_if.sv
// response channel interface
interface mbrb_rsp_if;
    logic          valid;
    logic          ready;
    mbrb_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/mbrb_front.sv
// front end: takes requests and decodes them into ring operations
module mbrb_front #(
    parameter int CHANNELS = mbrb_pkg::CHANNELS_DEFAULT
) (
    mbrb_req_if.sink        req,
    input  logic            queue_full,
    output logic            push,
    output mbrb_pkg::cmd_t  cmd
);
    import mbrb_pkg::*;

    always_comb
    begin
        req.ready        = !queue_full;
        push             = req.valid && !queue_full;
        cmd.channel      = req.payload.channel;
        cmd.direction    = req.payload.direction;
        cmd.data_in      = req.payload.data_in;
        cmd.rewind_count = req.payload.rewind_count;
        cmd.op           = OP_STATUS;
        if (int'(req.payload.channel) >= CHANNELS)
        begin
            cmd.op = OP_BAD_CHAN;
        end
        else
        begin
            case (req.payload.mode)
                MODE_PUT:    cmd.op = OP_PUT;
                MODE_GET:    cmd.op = OP_GET;
                // zero count rewind is refused
                MODE_REWIND: cmd.op = (req.payload.rewind_count == '0) ? OP_REFUSE : OP_REWIND;
                MODE_STATUS: cmd.op = OP_STATUS;
                default:     cmd.op = OP_STATUS;
            endcase
        end
    end
endmodule

FILE: hw/rtl/mbrb_cmd_queue.sv
// short command queue between front end and back end
module mbrb_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbrb_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output mbrb_pkg::cmd_t  head_cmd
);
    import mbrb_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == CW'(QUEUE_DEPTH));
        head_valid  = (count_reg != '0);
        head_cmd    = entry_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

FILE: hw/rtl/mbrb_ring.sv
// one direction's rings: per-channel pointers and byte store
module mbrb_ring #(
    parameter int CHANNELS = mbrb_pkg::CHANNELS_DEFAULT,
    parameter int DEPTH    = mbrb_pkg::RX_DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  mbrb_pkg::cmd_t               cmd,
    output mbrb_pkg::ring_stat_t         stat,
    output logic [mbrb_pkg::BYTE_W-1:0]  rd_data
);
    import mbrb_pkg::*;

    localparam int PW        = $clog2(DEPTH);
    localparam int EW        = PW + 1;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_WORDS = 1 << (CH_W + PW);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [PW-1:0]     rd_ptr_reg [CHANNELS];
    logic [PW-1:0]     wr_ptr_reg [CHANNELS];
    logic [BYTE_W-1:0] mem [MEM_WORDS];
    logic [BYTE_W-1:0] rd_data_reg;

    logic [PW-1:0]     mod_tab [256];
    logic [CH_W-1:0]   ch_idx;
    logic [PW-1:0]     rp, wp, rp_next, wp_next, step, used, free;

    // rewind count reduced modulo the ring depth
    for (genvar i = 0; i < 256; i++)
    begin : g_mod
        assign mod_tab[i] = PW'(i % DEPTH);
    end

    always_comb
    begin
        ch_idx  = CH_W'(cmd.channel);
        rp      = rd_ptr_reg[ch_idx];
        wp      = wr_ptr_reg[ch_idx];
        step    = mod_tab[cmd.rewind_count];
        rp_next = rp;
        wp_next = wp;
        case (cmd.op)
            OP_PUT:    wp_next = (wp == LAST) ? '0 : wp + 1'b1;
            OP_GET:    rp_next = (rp == LAST) ? '0 : rp + 1'b1;
            OP_REWIND: rp_next = (rp >= step) ? rp - step
                                              : PW'(EW'(rp) + EW'(DEPTH) - EW'(step));
            default:   rp_next = rp;
        endcase
        used = (wp_next >= rp_next) ? wp_next - rp_next
                                    : PW'(EW'(wp_next) + EW'(DEPTH) - EW'(rp_next));
        free = LAST - used;
        stat.used_count = COUNT_W'(used);
        stat.free_count = COUNT_W'(free);
        rd_data = rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            rd_ptr_reg[ch_idx] <= rp_next;
            wr_ptr_reg[ch_idx] <= wp_next;
        end
    end

    // byte store, read data registered
    always_ff @(posedge clk)
    begin
        if (fire && cmd.op == OP_PUT)
        begin
            mem[{ch_idx, wp}] <= cmd.data_in;
        end
        if (fire && cmd.op == OP_GET)
        begin
            rd_data_reg <= mem[{ch_idx, rp}];
        end
    end
endmodule

FILE: hw/rtl/mbrb_back.sv
// back end: executes ring operations and holds the response register
module mbrb_back #(
    parameter int CHANNELS = mbrb_pkg::CHANNELS_DEFAULT,
    parameter int RX_DEPTH = mbrb_pkg::RX_DEPTH_DEFAULT,
    parameter int TX_DEPTH = mbrb_pkg::TX_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  mbrb_pkg::cmd_t  head_cmd,
    output logic            pop,
    mbrb_rsp_if.source      rsp
);
    import mbrb_pkg::*;

    logic                advance, fire_rx, fire_tx, good_chan;
    ring_stat_t          rx_stat, tx_stat, sel_stat;
    logic [BYTE_W-1:0]   rx_rd, tx_rd;

    logic                res_valid_reg, res_valid_next;
    logic                res_get_reg, res_dir_reg, ok_reg;
    logic [COUNT_W-1:0]  used_reg, free_reg;

    always_comb
    begin
        advance   = head_valid && (!res_valid_reg || rsp.ready);
        pop       = advance;
        good_chan = (head_cmd.op != OP_BAD_CHAN);
        fire_rx   = advance && good_chan && (head_cmd.direction == DIR_RX);
        fire_tx   = advance && good_chan && (head_cmd.direction == DIR_TX);
        sel_stat  = (head_cmd.direction == DIR_TX) ? tx_stat : rx_stat;
        if (!good_chan)
        begin
            sel_stat = '0;
        end
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            res_valid_next = 1'b0;
        end
        rsp.valid              = res_valid_reg;
        rsp.payload.data_out   = res_get_reg ? (res_dir_reg ? tx_rd : rx_rd) : '0;
        rsp.payload.ok         = ok_reg;
        rsp.payload.used_count = used_reg;
        rsp.payload.free_count = free_reg;
    end

    mbrb_ring #(
        .CHANNELS (CHANNELS),
        .DEPTH    (RX_DEPTH)
    ) u_rx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire_rx),
        .cmd     (head_cmd),
        .stat    (rx_stat),
        .rd_data (rx_rd)
    );

    mbrb_ring #(
        .CHANNELS (CHANNELS),
        .DEPTH    (TX_DEPTH)
    ) u_tx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire_tx),
        .cmd     (head_cmd),
        .stat    (tx_stat),
        .rd_data (tx_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_get_reg <= (head_cmd.op == OP_GET);
            res_dir_reg <= head_cmd.direction;
            ok_reg      <= !(head_cmd.op inside {OP_REFUSE, OP_BAD_CHAN});
            used_reg    <= sel_stat.used_count;
            free_reg    <= sel_stat.free_count;
        end
    end
endmodule

FILE: hw/rtl/multichannel_byte_ring_buffer_unit.sv
// top level of the multichannel byte ring buffer
// path: a request transfer is written into the command queue, and the back end then
//   registers its response in the response register
// throughput: one request per cycle while the response is not stalled, set by the
//   back end's read-modify-write of the channel's pointer flops within the same cycle
// reset: rst_n clears all read and write pointers, the queue and the response valid;
//   the byte stores are not cleared and there is no clearing pass
module multichannel_byte_ring_buffer_unit #(
    parameter int CHANNELS = mbrb_pkg::CHANNELS_DEFAULT,
    parameter int RX_DEPTH = mbrb_pkg::RX_DEPTH_DEFAULT,
    parameter int TX_DEPTH = mbrb_pkg::TX_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    mbrb_req_if.sink    req,
    mbrb_rsp_if.source  rsp
);
    import mbrb_pkg::*;

    // front end to queue
    logic  queue_full;
    logic  push;
    cmd_t  push_cmd;

    // queue to back end
    logic  pop;
    logic  head_valid;
    cmd_t  head_cmd;

    // the front end decodes each request transfer: channel range check,
    // zero-count rewind refusal and the operation code
    mbrb_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .req        (req),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    // two-entry queue lets requests keep arriving while a response is stalled, until it is full
    mbrb_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // the back end owns the pointers and byte stores of both directions;
    // pointer updates land before the next operation is read, so
    // back-to-back operations on one ring need no extra forwarding
    mbrb_back #(
        .CHANNELS (CHANNELS),
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .rsp        (rsp)
    );
endmodule

FILE: hw/rtl/mbrb_checker.sv
// port-level checks of the multichannel byte ring buffer, bound to the top level
module mbrb_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_ready,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  mbrb_pkg::rsp_t  rsp_payload
);
    import mbrb_pkg::*;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("response changed while stalled");

    // a refused request never carries a byte
    a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_payload.ok |-> rsp_payload.data_out == '0)
        else $error("refused response carries data");

    // the request side only backs off after a stalled response
    a_backpressure_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> $past(rsp_valid && !rsp_ready))
        else $error("request not ready without response stall");

    // an offered request with room is taken at once
    a_req_taken: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !$past(rsp_valid && !rsp_ready) |-> req_ready)
        else $error("request refused with queue room");
endmodule

bind multichannel_byte_ring_buffer_unit mbrb_checker u_mbrb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
